### hw/rtl/uc_pkg.sv
// shared types, codes and constants for the utf-8 codec
package uc_pkg;

    // stream payload widths
    localparam int CP_W      = 31;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;

    // input selector codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_CODE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   byte_out;
        logic [CP_W-1:0]     code_out;
        logic                last;
    } t_result;

    // encoded length thresholds
    localparam logic [CP_W-1:0] LIM_2 = 31'd128;
    localparam logic [CP_W-1:0] LIM_3 = 31'd2048;
    localparam logic [CP_W-1:0] LIM_4 = 31'd65536;
    localparam logic [CP_W-1:0] LIM_5 = 31'd2097152;
    localparam logic [CP_W-1:0] LIM_6 = 31'd67108864;

    // lead byte prefix for a sequence of n bytes
    function automatic logic [BYTE_W-1:0] lead_prefix(input logic [CNT_W-1:0] n);
        logic [BYTE_W-1:0] p;
        case (n)
            3'd2:    p = 8'hC0;
            3'd3:    p = 8'hE0;
            3'd4:    p = 8'hF0;
            3'd5:    p = 8'hF8;
            3'd6:    p = 8'hFC;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/uc_enc.sv
// encoder byte generator: length and byte at a given position of a code point
module uc_enc
    import uc_pkg::*;
(
    input  logic [CP_W-1:0]   i_cp,
    input  logic [CNT_W-1:0]  i_pos,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  k;
    logic [BYTE_W-1:0] slice;

    // sequence length from the code point range
    always_comb begin
        if (i_cp < LIM_2)      len = 3'd1;
        else if (i_cp < LIM_3) len = 3'd2;
        else if (i_cp < LIM_4) len = 3'd3;
        else if (i_cp < LIM_5) len = 3'd4;
        else if (i_cp < LIM_6) len = 3'd5;
        else                   len = 3'd6;
    end

    // six-bit groups still to follow this byte
    assign k = 3'(len - 3'd1 - i_pos);

    // code point shifted right by 6*k
    always_comb begin
        case (k)
            3'd0:    slice = i_cp[7:0];
            3'd1:    slice = i_cp[13:6];
            3'd2:    slice = i_cp[19:12];
            3'd3:    slice = i_cp[25:18];
            3'd4:    slice = {1'b0, i_cp[30:24]};
            3'd5:    slice = {7'd0, i_cp[30]};
            default: slice = '0;
        endcase
    end

    // lead byte carries the prefix, the rest are continuation bytes
    always_comb begin
        if (i_pos == 3'd0) begin
            o_byte = lead_prefix(len) | slice;
        end else begin
            o_byte = {2'b10, slice[5:0]};
        end
    end

    assign o_last = (k == 3'd0);

endmodule

### hw/rtl/uc_dec.sv
// streaming decoder: sequence state and the result of one input byte
module uc_dec
    import uc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_has_result,
    output t_result           o_res
);

    logic [CP_W-1:0]  r_partial;
    logic [CNT_W-1:0] r_remain;
    logic [CP_W-1:0]  n_partial;
    logic [CNT_W-1:0] n_remain;
    logic [CP_W-1:0]  shifted;

    assign shifted = {r_partial[CP_W-7:0], i_byte[5:0]};

    // next state and result for the byte
    always_comb begin
        n_partial    = r_partial;
        n_remain     = r_remain;
        o_has_result = 1'b0;
        o_res.kind     = KIND_CODE;
        o_res.byte_out = '0;
        o_res.code_out = '0;
        o_res.last     = 1'b1;
        if (r_remain != 3'd0) begin
            // inside a sequence every byte is a continuation
            n_partial = shifted;
            n_remain  = 3'(r_remain - 3'd1);
            if (r_remain == 3'd1) begin
                o_has_result   = 1'b1;
                o_res.code_out = shifted;
            end
        end else if (i_byte < 8'h80) begin
            o_has_result   = 1'b1;
            o_res.code_out = {23'd0, i_byte};
        end else if (i_byte < 8'hC0 || i_byte >= 8'hFE) begin
            // lone continuation or invalid byte
            o_has_result   = 1'b1;
            o_res.kind     = KIND_ERR;
            o_res.byte_out = i_byte;
        end else if (i_byte < 8'hE0) begin
            n_remain  = 3'd1;
            n_partial = {26'd0, i_byte[4:0]};
        end else if (i_byte < 8'hF0) begin
            n_remain  = 3'd2;
            n_partial = {27'd0, i_byte[3:0]};
        end else if (i_byte < 8'hF8) begin
            n_remain  = 3'd3;
            n_partial = {28'd0, i_byte[2:0]};
        end else if (i_byte < 8'hFC) begin
            n_remain  = 3'd4;
            n_partial = {29'd0, i_byte[1:0]};
        end else begin
            n_remain  = 3'd5;
            n_partial = {30'd0, i_byte[0]};
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_remain  <= '0;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_remain  <= n_remain;
        end
    end

endmodule

### hw/rtl/utf8_codec.sv
// utf-8 codec top level: input register, encode/decode step, output register
// throughput: an encode item emits 1 to 6 bytes and a decode item at most one result item,
// set by the single output register that takes one byte a cycle unless the receiver stalls it
// reset: synchronous active low, clears both valid flags, the byte position and the decoder sequence state
module utf8_codec
    import uc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // code_point[30:0], byte_in[38:31], zero pad
    input  logic                  i_s_tuser,   // op
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // byte_out[7:0], code_out[38:8], zero pad
    output logic [1:0]            o_m_tuser,   // out_kind
    output logic                  o_m_tlast    // last
);

    logic              r_in_valid;
    logic              r_op;
    logic [CP_W-1:0]   r_cp;
    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_pos;
    logic              r_out_valid;
    t_result           r_res;

    logic              emit_ok;
    logic              enc_step;
    logic              dec_fire;
    logic              item_done;
    logic              produce;
    logic [BYTE_W-1:0] enc_byte;
    logic              enc_last;
    logic              dec_has;
    t_result           dec_res;
    t_result           n_res;

    uc_enc u_enc (
        .i_cp   (r_cp),
        .i_pos  (r_pos),
        .o_byte (enc_byte),
        .o_last (enc_last)
    );

    uc_dec u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (dec_fire),
        .i_byte       (r_byte),
        .o_has_result (dec_has),
        .o_res        (dec_res)
    );

    // step control
    assign emit_ok   = !r_out_valid || i_m_tready;
    assign enc_step  = r_in_valid && emit_ok && (r_op == OP_ENCODE);
    assign dec_fire  = r_in_valid && emit_ok && (r_op == OP_DECODE);
    assign item_done = dec_fire || (enc_step && enc_last);
    assign produce   = enc_step || (dec_fire && dec_has);
    assign o_s_tready = !r_in_valid || item_done;

    // result to load into the output register
    always_comb begin
        if (r_op == OP_ENCODE) begin
            n_res.kind     = KIND_BYTE;
            n_res.byte_out = enc_byte;
            n_res.code_out = '0;
            n_res.last     = enc_last;
        end else begin
            n_res = dec_res;
        end
    end

    // input register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (enc_step) begin
                r_pos <= enc_last ? 3'd0 : 3'(r_pos + 3'd1);
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op   <= i_s_tuser;
            r_cp   <= i_s_tdata[30:0];
            r_byte <= i_s_tdata[38:31];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (produce) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_res.code_out, r_res.byte_out};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;

endmodule

### dv/tb.sv
// testbench for the utf-8 codec: directed and random items checked against a built-in predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uc_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // code_point[30:0], byte_in[38:31], zero pad
    logic                  i_s_tuser;   // op
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // byte_out[7:0], code_out[38:8], zero pad
    logic [1:0]            o_m_tuser;   // out_kind
    logic                  o_m_tlast;   // last

    // expected result items, oldest first
    t_result exp_q[$];

    // decoder sequence state as predicted
    logic [CP_W-1:0]  dec_acc  = '0;
    logic [CNT_W-1:0] dec_left = '0;

    // bookkeeping
    int  n_items   = 0;
    int  n_enc     = 0;
    int  n_dec     = 0;
    int  n_results = 0;
    int  n_err     = 0;
    int  n_cycles  = 0;
    int  hold_left = 0;
    int  burst_left = 0;
    bit  gaps_on   = 1'b1;

    utf8_codec u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result items outstanding",
                     n_cycles, exp_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // lead byte marker bits for a sequence of n bytes
    function automatic logic [BYTE_W-1:0] lead_bits(int n);
        case (n)
            2:       return 8'hC0;
            3:       return 8'hE0;
            4:       return 8'hF0;
            5:       return 8'hF8;
            6:       return 8'hFC;
            default: return 8'h00;
        endcase
    endfunction

    // append one expected result item at the tail
    function automatic void queue_result(t_result r);
        exp_q = {exp_q, r};
    endfunction

    // encoded bytes of one code point
    function automatic void predict_encode(logic [CP_W-1:0] cp);
        int      n;
        int      sh;
        t_result r;
        n = (cp < LIM_2) ? 1 : (cp < LIM_3) ? 2 : (cp < LIM_4) ? 3 :
            (cp < LIM_5) ? 4 : (cp < LIM_6) ? 5 : 6;
        for (int i = 0; i < n; i++) begin
            sh         = 6 * (n - 1 - i);
            r.kind     = KIND_BYTE;
            r.code_out = '0;
            r.last     = (i == n - 1);
            if (i == 0) begin
                r.byte_out = lead_bits(n) | 8'(cp >> sh);
            end else begin
                r.byte_out = {2'b10, 6'(cp >> sh)};
            end
            queue_result(r);
        end
    endfunction

    // one decoded byte: advances the sequence state, may give one result
    function automatic void predict_decode(logic [BYTE_W-1:0] b);
        t_result r;
        r.kind     = KIND_CODE;
        r.byte_out = '0;
        r.code_out = '0;
        r.last     = 1'b1;
        if (dec_left != 0) begin
            // inside a sequence every byte counts as a continuation
            dec_acc  = {dec_acc[CP_W-7:0], b[5:0]};
            dec_left = dec_left - 1'b1;
            if (dec_left == 0) begin
                r.code_out = dec_acc;
                queue_result(r);
            end
        end else if (b < 8'h80) begin
            r.code_out = CP_W'(b);
            queue_result(r);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
            r.kind     = KIND_ERR;
            r.byte_out = b;
            queue_result(r);
        end else if (b < 8'hE0) begin
            dec_left = 3'd1;
            dec_acc  = CP_W'(b[4:0]);
        end else if (b < 8'hF0) begin
            dec_left = 3'd2;
            dec_acc  = CP_W'(b[3:0]);
        end else if (b < 8'hF8) begin
            dec_left = 3'd3;
            dec_acc  = CP_W'(b[2:0]);
        end else if (b < 8'hFC) begin
            dec_left = 3'd4;
            dec_acc  = CP_W'(b[1:0]);
        end else begin
            dec_left = 3'd5;
            dec_acc  = CP_W'(b[0]);
        end
    endfunction

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace();
        if (!gaps_on) return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // offer one item and wait until it is taken; called at a rising edge
    task automatic send_item(logic op, logic [CP_W-1:0] cp, logic [BYTE_W-1:0] b);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(IN_DATA_W-BYTE_W-CP_W){1'b0}}, b, cp};
        // ready seen at the falling edge means the item goes in at the next rising edge
        do @(negedge i_clk); while (!o_s_tready);
        if (op == OP_ENCODE) begin
            predict_encode(cp);
            n_enc++;
        end else begin
            predict_decode(b);
            n_dec++;
        end
        n_items++;
        @(posedge i_clk);
        pace();
    endtask

    // the unused field carries junk
    task automatic send_encode(logic [CP_W-1:0] cp);
        send_item(OP_ENCODE, cp, 8'($urandom));
    endtask

    task automatic send_decode(logic [BYTE_W-1:0] b);
        send_item(OP_DECODE, CP_W'($urandom), b);
    endtask

    // code point with an encoded length picked evenly from 1 to 6
    function automatic logic [CP_W-1:0] rand_point();
        case ($urandom_range(1, 6))
            1:       return CP_W'($urandom_range(LIM_2 - 1, 0));
            2:       return CP_W'($urandom_range(LIM_3 - 1, LIM_2));
            3:       return CP_W'($urandom_range(LIM_4 - 1, LIM_3));
            4:       return CP_W'($urandom_range(LIM_5 - 1, LIM_4));
            5:       return CP_W'($urandom_range(LIM_6 - 1, LIM_5));
            default: return CP_W'($urandom_range(32'h7FFF_FFFF, LIM_6));
        endcase
    endfunction

    // utf-8 byte sequence of len bytes, cut short if asked, encodes mixed in
    task automatic send_utf8_seq(int len, bit cut);
        int               keep;
        logic [BYTE_W-1:0] b;
        keep = cut ? $urandom_range(1, len - 1) : len;
        b    = 8'($urandom);
        if (len == 1) begin
            b[7] = 1'b0;
        end else begin
            b = lead_bits(len) | (b & (8'h7F >> len));
        end
        send_decode(b);
        for (int i = 1; i < keep; i++) begin
            if ($urandom_range(0, 9) == 0) send_encode(rand_point());
            b = 8'($urandom);
            // mostly proper continuation tags, sometimes anything
            if ($urandom_range(0, 7) != 0) b[7:6] = 2'b10;
            send_decode(b);
        end
    endtask

    // length boundaries of the encoder, smallest and largest code points
    task automatic test_encode_extremes();
        send_encode(31'd0);
        send_encode(31'd127);
        send_encode(31'd128);
        send_encode(31'd2047);
        send_encode(31'd2048);
        send_encode(31'd65535);
        send_encode(31'd65536);
        send_encode(31'd2097152);
        send_encode(31'd67108864);
        send_encode(31'h7FFF_FFFF);
    endtask

    // decoder corner cases
    task automatic test_decode_cases();
        // ascii extremes
        send_decode(8'h00);
        send_decode(8'h7F);
        // lone continuation, 0xfe and 0xff while idle
        send_decode(8'h80);
        send_decode(8'hFE);
        send_decode(8'hFF);
        // two-byte sequence giving code point 0xff
        send_decode(8'hC3);
        send_decode(8'hBF);
        // lead byte inside a sequence is taken as a continuation
        send_decode(8'hE2);
        send_decode(8'hF0);
        send_decode(8'h82);
        // six-byte sequence with an encode in the middle
        send_decode(8'hFC);
        send_decode(8'h80);
        send_encode(31'h41);
        send_decode(8'hBF);
        send_decode(8'hBF);
        send_decode(8'hBF);
        send_decode(8'hBF);
    endtask

    // long receiver hold while the sender keeps pushing six-byte encodes
    task automatic test_backpressure();
        gaps_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_encode(CP_W'($urandom_range(32'h7FFF_FFFF, LIM_6)));
        gaps_on = 1'b1;
    endtask

    // random mix: mostly well-formed sequences and encodes, some noise
    task automatic test_random_mix(int n_target);
        int first;
        int sel;
        first = n_items;
        while (n_items - first < n_target) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                send_encode(rand_point());
            end else if (sel < 85) begin
                send_utf8_seq($urandom_range(1, 6), 1'b0);
            end else if (sel < 93) begin
                send_utf8_seq($urandom_range(2, 6), 1'b1);
            end else begin
                send_decode(8'($urandom));
            end
        end
    endtask

    // receiver: rotating stall pattern, long hold on request
    initial begin : rx_stall
        int unsigned     phase;
        logic [15:0]     pat;
        phase = 0;
        pat   = '1;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= pat[phase % 16];
            end
            phase++;
            if (phase % 64 == 0) begin
                pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
        end
    end

    // one field of a result against its expectation
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            n_err++;
        end
    endtask

    // result checker, sampled at the falling edge before the accepting edge
    always @(negedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (exp_q.size() == 0) begin
                $error("unexpected result item: tuser 0x%0h tdata 0x%0h tlast %0b",
                       o_m_tuser, o_m_tdata, o_m_tlast);
                n_err++;
            end else begin
                want = exp_q.pop_front();
                check_field("out_kind", want.kind, o_m_tuser);
                check_field("byte_out", want.byte_out, o_m_tdata[BYTE_W-1:0]);
                check_field("code_out", want.code_out, o_m_tdata[BYTE_W +: CP_W]);
                check_field("last", want.last, o_m_tlast);
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_ENCODE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_extremes();
        test_decode_cases();
        test_backpressure();
        test_random_mix(460);

        // drain
        i_s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items (%0d encode, %0d decode), checked %0d result items",
                 n_items, n_enc, n_dec, n_results);
        $display("covered length boundaries, malformed bytes, cut sequences, long hold: %0d errors",
                 n_err);
        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/uc_pkg.sv
hw/rtl/uc_enc.sv
hw/rtl/uc_dec.sv
hw/rtl/utf8_codec.sv
dv/tb.sv
